// ----- design/dsv_pkg.sv -----
// Types, register codes and saturation helper for the damped spring vertex integrator.
package dsv_pkg;

  typedef logic signed [23:0] fix_t;

  localparam fix_t FIX_MAX = 24'sh7FFFFF;
  localparam fix_t FIX_MIN = 24'sh800000;

  // Squared speed threshold of 0.01 expressed in Q.16.
  localparam logic [49:0] MOVE_LIMIT = 50'd655;
  localparam logic [7:0]  SHADE_MIN  = 8'd179;
  localparam logic [7:0]  SHADE_MAX  = 8'd255;

  typedef enum logic [2:0] {
    REG_STIFFNESS   = 3'd0,
    REG_DAMPING     = 3'd1,
    REG_TIME_STEP   = 3'd2,
    REG_MAX_DEFORM  = 3'd3,
    REG_BODY_RADIUS = 3'd4
  } reg_index_t;

  typedef struct packed {
    fix_t rest_x;
    fix_t rest_y;
    fix_t rest_z;
    fix_t pos_x;
    fix_t pos_y;
    fix_t pos_z;
    fix_t vel_x;
    fix_t vel_y;
    fix_t vel_z;
  } vertex_in_t;

  typedef struct packed {
    fix_t       new_pos_x;
    fix_t       new_pos_y;
    fix_t       new_pos_z;
    fix_t       new_vel_x;
    fix_t       new_vel_y;
    fix_t       new_vel_z;
    logic       moving;
    logic [7:0] shade;
  } vertex_out_t;

  // Data that rides alongside the square root.
  typedef struct packed {
    fix_t [2:0]        rest;
    fix_t [2:0]        pos;
    fix_t [2:0]        vel;
    logic [2:0]        neg;
    logic [2:0][46:0]  prodm;
    logic              clamp;
  } sq_side_t;

  // Data that rides alongside the pull-back divider.
  typedef struct packed {
    fix_t [2:0] rest;
    fix_t [2:0] pos;
    fix_t [2:0] vel;
    logic [2:0] neg;
    logic       clamp;
  } dv_side_t;

  // Data that rides alongside the shade divider.
  typedef struct packed {
    fix_t [2:0] pos;
    fix_t [2:0] vel;
    logic       moving;
    logic       zpos;
    logic       big;
  } sh_side_t;

  function automatic fix_t sat24(input logic signed [39:0] x);
    fix_t r;
    if (x > 40'sd8388607) begin
      r = FIX_MAX;
    end else if (x < -40'sd8388608) begin
      r = FIX_MIN;
    end else begin
      r = x[23:0];
    end
    return r;
  endfunction

endpackage

// ----- design/damped_spring_vertex_integrator_unit.sv -----
// Top level of the damped spring vertex integrator: spring, damping, pull-back and shade pipeline.
//
// One vertex may be started in every clock cycle and busy never rises: the pipeline always
// moves, so every started vertex returns exactly one result, strobed by done for one cycle,
// in start order. On its way each vertex passes through the 25-stage square root of the
// squared displacement, the 24-stage divider that scales a displacement back onto the
// deformation radius, and the 7-stage divider of the height shade.
// Registers are written through wr_en, wr_index and wr_data and take effect for vertices
// started afterwards; they should only be changed while no result is outstanding.
module damped_spring_vertex_integrator_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  dsv_pkg::vertex_in_t item,
  output logic                done,
  output dsv_pkg::vertex_out_t result,
  input  logic                wr_en,
  input  logic [2:0]          wr_index,
  input  logic [22:0]         wr_data
);

  import dsv_pkg::*;

  localparam int SQ_SW = $bits(sq_side_t);
  localparam int DV_SW = $bits(dv_side_t);
  localparam int SH_SW = $bits(sh_side_t);

  // Configuration registers.
  logic [15:0] stiffness;
  logic [15:0] damping;
  logic [15:0] time_step;
  logic [22:0] max_deform;
  logic [22:0] body_radius;
  logic [45:0] deform_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      stiffness   <= 16'd2560;
      damping     <= 16'd1280;
      time_step   <= 16'd1092;
      max_deform  <= 23'd10240;
      body_radius <= 23'd25600;
    end else if (wr_en) begin
      case (wr_index)
        REG_STIFFNESS:   stiffness   <= wr_data[15:0];
        REG_DAMPING:     damping     <= wr_data[15:0];
        REG_TIME_STEP:   time_step   <= wr_data[15:0];
        REG_MAX_DEFORM:  max_deform  <= wr_data;
        REG_BODY_RADIUS: body_radius <= wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    deform_sq <= max_deform * max_deform;
  end

  assign busy = 1'b0;

  // Stage 1: capture the vertex.
  logic       s1_valid;
  fix_t [2:0] s1_rest, s1_pos, s1_vel;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
    end
    s1_rest <= {item.rest_z, item.rest_y, item.rest_x};
    s1_pos  <= {item.pos_z, item.pos_y, item.pos_x};
    s1_vel  <= {item.vel_z, item.vel_y, item.vel_x};
  end

  // Stage 2: displacement from rest.
  logic                     s2_valid;
  fix_t [2:0]               s2_rest, s2_pos, s2_vel;
  logic signed [24:0]       s2_d [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_rest <= s1_rest;
    s2_pos  <= s1_pos;
    s2_vel  <= s1_vel;
    for (int i = 0; i < 3; i++) begin
      s2_d[i] <= 25'(s1_pos[i]) - 25'(s1_rest[i]);
    end
  end

  // Stage 3: spring and damping products.
  logic                     s3_valid;
  fix_t [2:0]               s3_rest, s3_pos, s3_vel;
  logic signed [41:0]       s3_kd [3];
  logic signed [40:0]       s3_cv [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
    s3_rest <= s2_rest;
    s3_pos  <= s2_pos;
    s3_vel  <= s2_vel;
    for (int i = 0; i < 3; i++) begin
      s3_kd[i] <= $signed({1'b0, stiffness}) * s2_d[i];
      s3_cv[i] <= $signed({1'b0, damping}) * s2_vel[i];
    end
  end

  // Stage 4: total force.
  logic                     s4_valid;
  fix_t [2:0]               s4_rest, s4_pos, s4_vel;
  logic signed [42:0]       s4_force [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= s3_valid;
    end
    s4_rest <= s3_rest;
    s4_pos  <= s3_pos;
    s4_vel  <= s3_vel;
    for (int i = 0; i < 3; i++) begin
      s4_force[i] <= -43'(s3_kd[i]) - 43'(s3_cv[i]);
    end
  end

  // Stage 5: force times time step.
  logic                     s5_valid;
  fix_t [2:0]               s5_rest, s5_pos, s5_vel;
  logic signed [59:0]       s5_fdt [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else begin
      s5_valid <= s4_valid;
    end
    s5_rest <= s4_rest;
    s5_pos  <= s4_pos;
    s5_vel  <= s4_vel;
    for (int i = 0; i < 3; i++) begin
      s5_fdt[i] <= s4_force[i] * $signed({1'b0, time_step});
    end
  end

  // Stage 6: new velocity, rounded half up from Q.24 and saturated.
  logic                     s6_valid;
  fix_t [2:0]               s6_rest, s6_pos, s6_vel;
  logic signed [59:0]       fdt_rnd [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fdt_rnd[i] = s5_fdt[i] + 60'sd8388608;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_valid <= 1'b0;
    end else begin
      s6_valid <= s5_valid;
    end
    s6_rest <= s5_rest;
    s6_pos  <= s5_pos;
    for (int i = 0; i < 3; i++) begin
      s6_vel[i] <= sat24(40'(s5_vel[i]) + 40'($signed(fdt_rnd[i][59:24])));
    end
  end

  // Stage 7: velocity times time step.
  logic                     s7_valid;
  fix_t [2:0]               s7_rest, s7_pos, s7_vel;
  logic signed [40:0]       s7_pdt [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_valid <= 1'b0;
    end else begin
      s7_valid <= s6_valid;
    end
    s7_rest <= s6_rest;
    s7_pos  <= s6_pos;
    s7_vel  <= s6_vel;
    for (int i = 0; i < 3; i++) begin
      s7_pdt[i] <= s6_vel[i] * $signed({1'b0, time_step});
    end
  end

  // Stage 8: new position, rounded half up from Q.16 and saturated.
  logic                     s8_valid;
  fix_t [2:0]               s8_rest, s8_pos, s8_vel;
  logic signed [40:0]       pdt_rnd [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pdt_rnd[i] = s7_pdt[i] + 41'sd32768;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s8_valid <= 1'b0;
    end else begin
      s8_valid <= s7_valid;
    end
    s8_rest <= s7_rest;
    s8_vel  <= s7_vel;
    for (int i = 0; i < 3; i++) begin
      s8_pos[i] <= sat24(40'(s7_pos[i]) + 40'($signed(pdt_rnd[i][40:16])));
    end
  end

  // Stage 9: deviation of the new position from rest.
  logic                     s9_valid;
  fix_t [2:0]               s9_rest, s9_pos, s9_vel;
  logic signed [24:0]       s9_dev [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s9_valid <= 1'b0;
    end else begin
      s9_valid <= s8_valid;
    end
    s9_rest <= s8_rest;
    s9_pos  <= s8_pos;
    s9_vel  <= s8_vel;
    for (int i = 0; i < 3; i++) begin
      s9_dev[i] <= 25'(s8_pos[i]) - 25'(s8_rest[i]);
    end
  end

  // Stage 10: squared deviations, and the magnitudes scaled by the deformation radius.
  logic                     s10_valid;
  fix_t [2:0]               s10_rest, s10_pos, s10_vel;
  logic [2:0]               s10_neg;
  logic [47:0]              s10_sq [3];
  logic [2:0][46:0]         s10_prodm;
  logic signed [49:0]       dev_sq [3];
  logic [23:0]              dev_mag [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dev_sq[i]  = s9_dev[i] * s9_dev[i];
      dev_mag[i] = s9_dev[i][24] ? 24'(-s9_dev[i]) : s9_dev[i][23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s10_valid <= 1'b0;
    end else begin
      s10_valid <= s9_valid;
    end
    s10_rest <= s9_rest;
    s10_pos  <= s9_pos;
    s10_vel  <= s9_vel;
    for (int i = 0; i < 3; i++) begin
      s10_neg[i]   <= s9_dev[i][24];
      s10_sq[i]    <= dev_sq[i][47:0];
      s10_prodm[i] <= dev_mag[i] * max_deform;
    end
  end

  // Stage 11: squared length of the deviation.
  logic                     s11_valid;
  fix_t [2:0]               s11_rest, s11_pos, s11_vel;
  logic [2:0]               s11_neg;
  logic [2:0][46:0]         s11_prodm;
  logic [49:0]              s11_dist2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s11_valid <= 1'b0;
    end else begin
      s11_valid <= s10_valid;
    end
    s11_rest  <= s10_rest;
    s11_pos   <= s10_pos;
    s11_vel   <= s10_vel;
    s11_neg   <= s10_neg;
    s11_prodm <= s10_prodm;
    s11_dist2 <= 50'(s10_sq[0]) + 50'(s10_sq[1]) + 50'(s10_sq[2]);
  end

  // Length of the deviation, needed only when the vertex is pulled back.
  sq_side_t    sq_in_side, sq_out_side;
  logic        sq_out_valid;
  logic [24:0] sq_len;

  always_comb begin
    sq_in_side.rest  = s11_rest;
    sq_in_side.pos   = s11_pos;
    sq_in_side.vel   = s11_vel;
    sq_in_side.neg   = s11_neg;
    sq_in_side.prodm = s11_prodm;
    sq_in_side.clamp = s11_dist2 > 50'(deform_sq);
  end

  dsv_sqrt #(
    .VW (50),
    .SW (SQ_SW)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s11_valid),
    .value     (s11_dist2),
    .in_side   (sq_in_side),
    .out_valid (sq_out_valid),
    .root      (sq_len),
    .out_side  (sq_out_side)
  );

  // Dividend for the pull-back, with half the divisor added for rounding.
  logic             sn_valid;
  logic [2:0][47:0] sn_num;
  logic [24:0]      sn_den;
  dv_side_t         sn_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      sn_valid <= 1'b0;
    end else begin
      sn_valid <= sq_out_valid;
    end
    for (int i = 0; i < 3; i++) begin
      sn_num[i] <= 48'(sq_out_side.prodm[i]) + 48'(sq_len >> 1);
    end
    // The length is only zero when no pull-back happens; keep the divisor sane anyway.
    sn_den        <= (sq_len == '0) ? 25'd1 : sq_len;
    sn_side.rest  <= sq_out_side.rest;
    sn_side.pos   <= sq_out_side.pos;
    sn_side.vel   <= sq_out_side.vel;
    sn_side.neg   <= sq_out_side.neg;
    sn_side.clamp <= sq_out_side.clamp;
  end

  logic             dv_out_valid;
  logic [2:0][23:0] dv_quo;
  dv_side_t         dv_out_side;

  dsv_div #(
    .LANES (3),
    .NW    (48),
    .DW    (25),
    .QW    (24),
    .SW    (DV_SW)
  ) u_pull_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sn_valid),
    .num       (sn_num),
    .den       (sn_den),
    .in_side   (sn_side),
    .out_valid (dv_out_valid),
    .quo       (dv_quo),
    .out_side  (dv_out_side)
  );

  // Final position and velocity after the optional pull-back.
  logic       sf_valid;
  fix_t [2:0] sf_pos, sf_vel;

  always_ff @(posedge clk) begin
    if (rst) begin
      sf_valid <= 1'b0;
    end else begin
      sf_valid <= dv_out_valid;
    end
    for (int i = 0; i < 3; i++) begin
      if (dv_out_side.clamp) begin
        sf_pos[i] <= sat24(40'(dv_out_side.rest[i]) +
                           (dv_out_side.neg[i] ? -40'(dv_quo[i]) : 40'(dv_quo[i])));
        sf_vel[i] <= dv_out_side.vel[i] >>> 1;
      end else begin
        sf_pos[i] <= dv_out_side.pos[i];
        sf_vel[i] <= dv_out_side.vel[i];
      end
    end
  end

  // Squared speeds and the shade comparisons.
  logic               sg_valid;
  fix_t [2:0]         sg_pos, sg_vel;
  logic [47:0]        sg_vsq [3];
  logic               sg_zpos, sg_big;
  logic [29:0]        sg_n90;
  logic signed [47:0] vel_sq [3];
  logic [22:0]        z_mag;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vel_sq[i] = sf_vel[i] * sf_vel[i];
    end
    z_mag = sf_pos[2][22:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sg_valid <= 1'b0;
    end else begin
      sg_valid <= sf_valid;
    end
    sg_pos <= sf_pos;
    sg_vel <= sf_vel;
    for (int i = 0; i < 3; i++) begin
      sg_vsq[i] <= vel_sq[i];
    end
    sg_zpos <= !sf_pos[2][23] && (sf_pos[2] != '0);
    sg_big  <= (29'(z_mag) * 29'd20) >= (29'(body_radius) * 29'd17);
    sg_n90  <= 30'(z_mag) * 30'd90;
  end

  // Moving flag from the summed squared speed.
  logic        sh_valid;
  logic [29:0] sh_n90;
  sh_side_t    sh_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      sh_valid <= 1'b0;
    end else begin
      sh_valid <= sg_valid;
    end
    sh_n90         <= sg_n90;
    sh_side.pos    <= sg_pos;
    sh_side.vel    <= sg_vel;
    sh_side.zpos   <= sg_zpos;
    sh_side.big    <= sg_big;
    sh_side.moving <= (50'(sg_vsq[0]) + 50'(sg_vsq[1]) + 50'(sg_vsq[2])) > MOVE_LIMIT;
  end

  logic            sd_out_valid;
  logic [0:0][6:0] sd_quo;
  sh_side_t        sd_out_side;

  dsv_div #(
    .LANES (1),
    .NW    (30),
    .DW    (23),
    .QW    (7),
    .SW    (SH_SW)
  ) u_shade_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sh_valid),
    .num       (sh_n90),
    .den       (body_radius),
    .in_side   (sh_side),
    .out_valid (sd_out_valid),
    .quo       (sd_quo),
    .out_side  (sd_out_side)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= sd_out_valid;
    end
    result.new_pos_x <= sd_out_side.pos[0];
    result.new_pos_y <= sd_out_side.pos[1];
    result.new_pos_z <= sd_out_side.pos[2];
    result.new_vel_x <= sd_out_side.vel[0];
    result.new_vel_y <= sd_out_side.vel[1];
    result.new_vel_z <= sd_out_side.vel[2];
    result.moving    <= sd_out_side.moving;
    if (!sd_out_side.zpos) begin
      result.shade <= SHADE_MIN;
    end else if (sd_out_side.big) begin
      result.shade <= SHADE_MAX;
    end else begin
      result.shade <= SHADE_MIN + 8'(sd_quo[0]);
    end
  end

endmodule

// ----- design/dsv_sqrt.sv -----
// Pipelined integer square root, one result bit per stage.
module dsv_sqrt #(
  parameter int VW = 50,
  parameter int SW = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [VW-1:0]       value,
  input  logic [SW-1:0]       in_side,
  output logic                out_valid,
  output logic [VW/2-1:0]     root,
  output logic [SW-1:0]       out_side
);

  localparam int RW = VW / 2;

  logic          valid_st [RW+1];
  logic [VW-1:0] rem_st   [RW+1];
  logic [VW-1:0] r_st     [RW+1];
  logic [SW-1:0] side_st  [RW+1];

  assign valid_st[0] = in_valid;
  assign rem_st[0]   = value;
  assign r_st[0]     = '0;
  assign side_st[0]  = in_side;

  for (genvar s = 0; s < RW; s++) begin : g_step
    localparam logic [VW:0] BIT = {{VW{1'b0}}, 1'b1} << (VW - 2 - 2 * s);
    logic [VW:0] trial;

    assign trial = {1'b0, r_st[s]} + BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        valid_st[s+1] <= 1'b0;
      end else begin
        valid_st[s+1] <= valid_st[s];
      end
      side_st[s+1] <= side_st[s];
      if ({1'b0, rem_st[s]} >= trial) begin
        rem_st[s+1] <= rem_st[s] - trial[VW-1:0];
        r_st[s+1]   <= (r_st[s] >> 1) + BIT[VW-1:0];
      end else begin
        rem_st[s+1] <= rem_st[s];
        r_st[s+1]   <= r_st[s] >> 1;
      end
    end
  end

  assign out_valid = valid_st[RW];
  assign root      = r_st[RW][RW-1:0];
  assign out_side  = side_st[RW];

endmodule

// ----- design/dsv_div.sv -----
// Pipelined restoring divider, several lanes sharing one divisor, one quotient bit per stage.
module dsv_div #(
  parameter int LANES = 1,
  parameter int NW    = 30,
  parameter int DW    = 23,
  parameter int QW    = 7,
  parameter int SW    = 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [LANES-1:0][NW-1:0]    num,
  input  logic [DW-1:0]               den,
  input  logic [SW-1:0]               in_side,
  output logic                        out_valid,
  output logic [LANES-1:0][QW-1:0]    quo,
  output logic [SW-1:0]               out_side
);

  localparam int CW = NW + DW;

  logic                     valid_st [QW+1];
  logic [LANES-1:0][NW-1:0] rem_st   [QW+1];
  logic [LANES-1:0][QW-1:0] quo_st   [QW+1];
  logic [DW-1:0]            den_st   [QW+1];
  logic [SW-1:0]            side_st  [QW+1];

  assign valid_st[0] = in_valid;
  assign rem_st[0]   = num;
  assign quo_st[0]   = '0;
  assign den_st[0]   = den;
  assign side_st[0]  = in_side;

  // The quotient is assumed to fit in QW bits; the top stage tests the largest shift.
  for (genvar s = 0; s < QW; s++) begin : g_step
    localparam int SH = QW - 1 - s;
    logic [CW-1:0]            dshift;
    logic [LANES-1:0]         ge;
    logic [LANES-1:0][NW-1:0] rem_nx;

    assign dshift = CW'(den_st[s]) << SH;

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        ge[l]     = CW'(rem_st[s][l]) >= dshift;
        rem_nx[l] = ge[l] ? rem_st[s][l] - dshift[NW-1:0] : rem_st[s][l];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid_st[s+1] <= 1'b0;
      end else begin
        valid_st[s+1] <= valid_st[s];
      end
      side_st[s+1] <= side_st[s];
      den_st[s+1]  <= den_st[s];
      rem_st[s+1]  <= rem_nx;
      for (int l = 0; l < LANES; l++) begin
        quo_st[s+1][l] <= {quo_st[s][l][QW-2:0], ge[l]};
      end
    end
  end

  assign out_valid = valid_st[QW];
  assign quo       = quo_st[QW];
  assign out_side  = side_st[QW];

endmodule

// ----- design/dsv_chk.sv -----
// Port-level checks for the damped spring vertex integrator, bound to the top level.
module dsv_chk (
  input logic                 clk,
  input logic                 rst,
  input logic                 busy,
  input logic                 done,
  input dsv_pkg::vertex_out_t result
);

  import dsv_pkg::*;

  // A result transfer never directly follows a reset cycle.
  a_no_done_after_reset: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobed straight after reset");

  // The pipeline never refuses a vertex.
  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  // A vertex at or below zero height gets the darkest shade.
  a_low_shade: assert property (@(posedge clk) disable iff (rst)
    done && (result.new_pos_z <= 0) |-> result.shade == SHADE_MIN)
    else $error("shade wrong for non-positive height");

  // Not moving means every velocity component is tiny.
  a_still_slow: assert property (@(posedge clk) disable iff (rst)
    done && !result.moving |->
      (result.new_vel_x <= 25) && (result.new_vel_x >= -25) &&
      (result.new_vel_y <= 25) && (result.new_vel_y >= -25) &&
      (result.new_vel_z <= 25) && (result.new_vel_z >= -25))
    else $error("moving flag clear with a fast vertex");

  // Shade never drops below its floor.
  a_shade_floor: assert property (@(posedge clk) disable iff (rst)
    done |-> result.shade >= SHADE_MIN)
    else $error("shade below its minimum");

endmodule

bind damped_spring_vertex_integrator_unit dsv_chk u_dsv_chk (
  .clk    (clk),
  .rst    (rst),
  .busy   (busy),
  .done   (done),
  .result (result)
);

// ----- bench/dsv_result_checker.sv -----
// Checker for the damped spring vertex integrator: predicts each vertex update and compares.
module dsv_result_checker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 busy,
  input  dsv_pkg::vertex_in_t  item,
  input  logic                 done,
  input  dsv_pkg::vertex_out_t result,
  input  logic                 wr_en,
  input  logic [2:0]           wr_index,
  input  logic [22:0]          wr_data,
  output int                   fail_count,
  output int                   pending
);
  import dsv_pkg::*;

  logic [15:0] stiffness, damping, time_step;
  logic [22:0] max_deform, body_radius;
  vertex_out_t expected_q[$];
  int clamp_seen, sat_seen;

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  function automatic longint fl_shift(input longint x, input int n);
    return x >>> n;
  endfunction

  function automatic longint sat(input longint x);
    if (x > 64'sd8388607) return 64'sd8388607;
    if (x < -64'sd8388608) return -64'sd8388608;
    return x;
  endfunction

  function automatic longint int_sqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic vertex_out_t integrate_vertex(input vertex_in_t v);
    longint rest[3], pos[3], vel[3], dev[3];
    longint k, c, dt, m, r, spring_force, z, q;
    longint unsigned dist2, speed2, len, mag;
    vertex_out_t o;
    k = stiffness; c = damping; dt = time_step; m = max_deform; r = body_radius;
    rest = '{longint'(v.rest_x), longint'(v.rest_y), longint'(v.rest_z)};
    pos  = '{longint'(v.pos_x), longint'(v.pos_y), longint'(v.pos_z)};
    vel  = '{longint'(v.vel_x), longint'(v.vel_y), longint'(v.vel_z)};
    dist2 = 0;
    speed2 = 0;
    for (int i = 0; i < 3; i++) begin
      spring_force = -(k * (pos[i] - rest[i])) - c * vel[i];
      vel[i] = sat(vel[i] + fl_shift(spring_force * dt + (64'sd1 <<< 23), 24));
      pos[i] = sat(pos[i] + fl_shift(vel[i] * dt + (64'sd1 <<< 15), 16));
      if (pos[i] == 64'sd8388607 || pos[i] == -64'sd8388608) sat_seen++;
      dev[i] = pos[i] - rest[i];
      dist2 += dev[i] * dev[i];
    end
    if (dist2 > longint'(m * m)) begin
      clamp_seen++;
      len = int_sqrt(dist2);
      for (int i = 0; i < 3; i++) begin
        mag = dev[i] < 0 ? -dev[i] : dev[i];
        q = (mag * m + len / 2) / len;
        pos[i] = sat(rest[i] + (dev[i] < 0 ? -q : q));
        vel[i] = fl_shift(vel[i], 1);
      end
    end
    for (int i = 0; i < 3; i++) speed2 += vel[i] * vel[i];
    z = pos[2];
    if (z <= 0) o.shade = SHADE_MIN;
    else if (20 * z >= 17 * r) o.shade = SHADE_MAX;
    else o.shade = 8'(179 + (90 * z) / r);
    o.new_pos_x = pos[0][23:0]; o.new_pos_y = pos[1][23:0]; o.new_pos_z = pos[2][23:0];
    o.new_vel_x = vel[0][23:0]; o.new_vel_y = vel[1][23:0]; o.new_vel_z = vel[2][23:0];
    o.moving = speed2 > 655;
    return o;
  endfunction

  always @(posedge clk) begin
    vertex_out_t e;
    if (rst) begin
      stiffness <= 16'd2560; damping <= 16'd1280; time_step <= 16'd1092;
      max_deform <= 23'd10240; body_radius <= 23'd25600;
    end else begin
      if (done) begin
        if (expected_q.size() == 0) begin
          report("result with nothing expected");
        end else begin
          e = expected_q.pop_front();
          if (result.new_pos_x !== e.new_pos_x) report("new_pos_x");
          if (result.new_pos_y !== e.new_pos_y) report("new_pos_y");
          if (result.new_pos_z !== e.new_pos_z) report("new_pos_z");
          if (result.new_vel_x !== e.new_vel_x) report("new_vel_x");
          if (result.new_vel_y !== e.new_vel_y) report("new_vel_y");
          if (result.new_vel_z !== e.new_vel_z) report("new_vel_z");
          if (result.moving !== e.moving) report("moving");
          if (result.shade !== e.shade) report("shade");
        end
      end
      if (start && !busy) expected_q.push_back(integrate_vertex(item));
      if (wr_en) begin
        case (wr_index)
          REG_STIFFNESS:   stiffness <= wr_data[15:0];
          REG_DAMPING:     damping <= wr_data[15:0];
          REG_TIME_STEP:   time_step <= wr_data[15:0];
          REG_MAX_DEFORM:  max_deform <= wr_data;
          REG_BODY_RADIUS: body_radius <= wr_data;
          default: ;
        endcase
      end
    end
    pending = expected_q.size();
  end

  initial fail_count = 0;
  initial pending = 0;
  initial clamp_seen = 0;
  initial sat_seen = 0;
endmodule

// ----- bench/tb_damped_spring_vertex_integrator_unit.sv -----
// Testbench top for the damped spring vertex integrator: stimulus, settings sweep and verdict.
module tb_damped_spring_vertex_integrator_unit;
  import dsv_pkg::*;

  // Register index that no register answers to.
  localparam logic [2:0] BAD_INDEX = 3'd7;

  logic clk = 0, rst = 1, start = 0, wr_en = 0;
  logic [2:0] wr_index = '0;
  logic [22:0] wr_data = '0;
  vertex_in_t item = '0;
  logic busy, done;
  vertex_out_t result;
  int fail_count, pending, sent;

  always #10 clk = ~clk;

  damped_spring_vertex_integrator_unit i_dut (
    .clk, .rst, .start, .busy, .item, .done, .result, .wr_en, .wr_index, .wr_data
  );

  dsv_result_checker i_checker (
    .clk, .rst, .start, .busy, .item, .done, .result, .wr_en, .wr_index, .wr_data,
    .fail_count, .pending
  );

  // One write, with wr_en lowered again before the task returns, so that writes never share a time step.
  task automatic write_reg(input logic [2:0] idx, input logic [22:0] value);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= value;
    @(posedge clk);
    wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Drain the pipeline fully before touching the registers.
  task automatic wait_drain();
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // Holds start high across back-to-back transfers; lowered only when a gap follows.
  task automatic send_vertex(input vertex_in_t v, input bit hold);
    item <= v;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
    if (!hold) start <= 1'b0;
  endtask

  function automatic fix_t rand_fix(input int mode);
    case (mode)
      0: return fix_t'($urandom());
      1: return fix_t'($urandom_range(0, 20000)) - fix_t'(10000);
      2: return ($urandom_range(0, 1)) ? FIX_MAX : FIX_MIN;
      default: return fix_t'($urandom_range(0, 2000)) - fix_t'(1000);
    endcase
  endfunction

  function automatic vertex_in_t rand_vertex();
    vertex_in_t v;
    int mode;
    mode = $urandom_range(0, 9);
    mode = mode < 1 ? 0 : mode < 2 ? 2 : mode < 6 ? 1 : 3;
    v.rest_x = rand_fix(mode); v.rest_y = rand_fix(mode); v.rest_z = rand_fix(mode);
    // Positions mostly near rest so both clamped and free updates occur.
    v.pos_x = ($urandom_range(0, 3) == 0) ? rand_fix(0) : v.rest_x + rand_fix(3) * 16;
    v.pos_y = ($urandom_range(0, 3) == 0) ? rand_fix(0) : v.rest_y + rand_fix(3) * 16;
    v.pos_z = ($urandom_range(0, 3) == 0) ? rand_fix(0) : v.rest_z + rand_fix(3) * 16;
    v.vel_x = rand_fix(mode); v.vel_y = rand_fix(mode); v.vel_z = rand_fix(mode);
    return v;
  endfunction

  function automatic vertex_in_t make_vertex(input fix_t r, input fix_t p, input fix_t w);
    return '{r, r, r, p, p, p, w, w, w};
  endfunction

  initial begin
    vertex_in_t v;
    int burst;
    sent = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: field extremes, at rest, saturation and values near the thresholds.
    send_vertex(make_vertex('0, '0, '0), 1);
    send_vertex(make_vertex(FIX_MAX, FIX_MAX, FIX_MAX), 1);
    send_vertex(make_vertex(FIX_MIN, FIX_MIN, FIX_MIN), 1);
    send_vertex(make_vertex(FIX_MIN, FIX_MAX, FIX_MIN), 1);
    send_vertex(make_vertex(FIX_MAX, FIX_MIN, FIX_MAX), 1);
    send_vertex(make_vertex('0, 24'sd100, 24'sd26), 1);
    send_vertex(make_vertex('0, 24'sd21760, '0), 1);
    send_vertex(make_vertex(24'sd20000, 24'sd20000, '0), 1);
    send_vertex(make_vertex('0, 24'sd30000, 24'sd5000), 1);
    send_vertex(make_vertex('0, -24'sd30000, -24'sd5000), 0);
    wait_drain();

    // Each step of the sweep writes every register, extremes included.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_STIFFNESS, 23'hFFFF); write_reg(REG_DAMPING, 23'hFFFF);
          write_reg(REG_TIME_STEP, 23'hFFFF); write_reg(REG_MAX_DEFORM, 23'h7FFFFF);
          write_reg(REG_BODY_RADIUS, 23'h7FFFFF);
        end
        1: begin
          write_reg(REG_STIFFNESS, 23'd0); write_reg(REG_DAMPING, 23'd0);
          write_reg(REG_TIME_STEP, 23'd0); write_reg(REG_MAX_DEFORM, 23'd0);
          write_reg(REG_BODY_RADIUS, 23'd0);
        end
        2: begin
          write_reg(REG_STIFFNESS, 23'd0); write_reg(REG_DAMPING, 23'd256);
          write_reg(REG_TIME_STEP, 23'hFFFF); write_reg(REG_MAX_DEFORM, 23'd0);
          write_reg(REG_BODY_RADIUS, 23'd1);
        end
        3: begin
          // An unknown index must leave every register untouched.
          write_reg(BAD_INDEX, 23'h7FFFFF);
          write_reg(REG_STIFFNESS, 23'(1000 + $urandom_range(0, 20000)));
          write_reg(REG_DAMPING, 23'($urandom_range(0, 65535)));
          write_reg(REG_TIME_STEP, 23'($urandom_range(0, 4000)));
          write_reg(REG_MAX_DEFORM, 23'($urandom_range(0, 40000)));
          write_reg(REG_BODY_RADIUS, 23'($urandom_range(1, 60000)));
        end
        4: begin
          write_reg(REG_STIFFNESS, 23'd2560); write_reg(REG_DAMPING, 23'd1280);
          write_reg(REG_TIME_STEP, 23'd1092); write_reg(REG_MAX_DEFORM, 23'd10240);
          write_reg(REG_BODY_RADIUS, 23'd25600);
        end
        default: begin
          write_reg(REG_STIFFNESS, 23'($urandom_range(0, 65535)));
          write_reg(REG_DAMPING, 23'($urandom_range(0, 65535)));
          write_reg(REG_TIME_STEP, 23'($urandom_range(0, 65535)));
          write_reg(REG_MAX_DEFORM, 23'($urandom_range(0, 23'h7FFFFF)));
          write_reg(REG_BODY_RADIUS, 23'($urandom_range(1, 23'h7FFFFF)));
        end
      endcase
      for (int n = 0; n < 320; ) begin
        burst = $urandom_range(1, 40);
        // The last transfer of a burst always lowers start itself.
        for (int b = 0; b < burst && n < 320; b++, n++) begin
          v = rand_vertex();
          send_vertex(v, (b < burst - 1) && (n < 319));
        end
        if (n == 160 && phase == 2) begin
          while (pending != 0) @(posedge clk);
        end else if ($urandom_range(0, 2) != 0) begin
          repeat ($urandom_range(1, 12)) @(posedge clk);
        end
      end
      wait_drain();
    end

    $display("Sent %0d vertices over seven register settings, %0d were pulled back.",
             sent, i_checker.clamp_seen);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("FAILED: results differ");
    $finish;
  end
endmodule
